// ===== rtl/contact_table_with_aging_macros.svh =====
// ---------------------------------------------------------------------------
// Contact table assertion macros
// Shared check shorthands, clocked on clk and held off during reset.
// ---------------------------------------------------------------------------
`ifndef CONTACT_TABLE_WITH_AGING_MACROS_SVH
`define CONTACT_TABLE_WITH_AGING_MACROS_SVH

// Condition that must hold in the same cycle as its trigger
`define CTA_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("contact table check failed");

// Condition that must hold in the cycle after its trigger
`define CTA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("contact table check failed");

`endif

// ===== rtl/cta_pkg.sv =====
// ---------------------------------------------------------------------------
// Contact table package
// Sizes, codes and shared types of the contact table with aging.
// ---------------------------------------------------------------------------
package cta_pkg;

  localparam int CAPACITY  = 16;
  localparam int IDX_W     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W     = $clog2(CAPACITY + 1);
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 32;

  localparam logic [15:0] MIN_PERIOD_MS   = 16'd33;
  localparam logic [31:0] RST_TYPE_MASK   = 32'hFFFF_FFFF;
  localparam logic [15:0] RST_TIMEOUT_MS  = 16'd250;
  localparam logic [15:0] RST_PERIOD_MS   = 16'd250;

  typedef enum logic [1:0] {
    OP_COLLIDE = 2'd0,
    OP_TICK    = 2'd1,
    OP_DELETE  = 2'd2,
    OP_ENABLE  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    KIND_NONE     = 3'd0,
    KIND_ENTER    = 3'd1,
    KIND_CONTACT  = 3'd2,
    KIND_LEAVE    = 3'd3,
    KIND_ENABLED  = 3'd4,
    KIND_DISABLED = 3'd5,
    KIND_REJECTED = 3'd6
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TYPE_MASK  = 2'd0,
    CFG_TIMEOUT    = 2'd1,
    CFG_PERIOD     = 2'd2
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SUM_T,
    ST_SUM_P,
    ST_RD,
    ST_EV,
    ST_CON,
    ST_ADD,
    ST_MARK,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic [15:0] id;
    logic [31:0] expiry;
    logic [31:0] next_contact;
  } entry_t;

  typedef enum logic {
    TU_ADD = 1'b0,
    TU_SUB = 1'b1
  } tu_op_t;

  typedef struct packed {
    tu_op_t      op;
    logic [31:0] a;
    logic [31:0] b;
  } tu_req_t;

  typedef struct packed {
    logic [31:0] sum;
    logic        reached;
  } tu_rsp_t;

endpackage

// ===== rtl/cta_in_if.sv =====
// ---------------------------------------------------------------------------
// Contact table input channel
// Valid/ready channel carrying one event item.
// ---------------------------------------------------------------------------
interface cta_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [31:0] now_ms;
  logic [15:0] object_id;
  logic [31:0] object_type;
  logic        enable_value;

  modport source (output valid, output op, output now_ms, output object_id,
                  output object_type, output enable_value, input ready);
  modport sink   (input valid, input op, input now_ms, input object_id,
                  input object_type, input enable_value, output ready);
endinterface

// ===== rtl/cta_out_if.sv =====
// ---------------------------------------------------------------------------
// Contact table result channel
// Valid/ready channel carrying one report.
// ---------------------------------------------------------------------------
interface cta_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [15:0] who;
  logic        last;

  modport source (output valid, output kind, output who, output last, input ready);
  modport sink   (input valid, input kind, input who, input last, output ready);
endinterface

// ===== rtl/cta_ram.sv =====
// ---------------------------------------------------------------------------
// Contact table RAM
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module cta_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                       wr_data,
  input  logic                                   rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port, holds when not enabled
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/cta_time_unit.sv =====
// ---------------------------------------------------------------------------
// Contact table time unit
// Shared 32-bit adder: forms deadlines and wrap-safe "time reached" tests.
// ---------------------------------------------------------------------------
module cta_time_unit (
  input  cta_pkg::tu_req_t req,
  output cta_pkg::tu_rsp_t rsp
);
  import cta_pkg::*;

  logic [31:0] b_op;
  logic [31:0] sum;

  // Subtract by adding the complement
  assign b_op = (req.op == TU_SUB) ? ~req.b : req.b;
  assign sum  = req.a + b_op + {31'd0, (req.op == TU_SUB)};

  // A deadline has come when now - deadline lands in the lower half
  assign rsp.sum     = sum;
  assign rsp.reached = ~sum[31];

endmodule

// ===== rtl/contact_table_with_aging.sv =====
// ---------------------------------------------------------------------------
// Contact table with aging
// Tracks objects touching a region, ages them out and reports changes.
// ---------------------------------------------------------------------------
// Usage:
//   in_ch  : event items (collision, tick, delete, set enable), valid/ready.
//   out_ch : reports (kind, who, last); every item yields one or more
//            reports, the final one flagged by last.
//   cfg_*  : write-only registers type_mask, timeout_ms, contact_period_ms;
//            write them only while the block is idle.
// Sequence: the block takes one item at a time. States SUM_T and SUM_P form
//   the new expiry and contact deadlines in the shared 32-bit time unit,
//   then the sequencer walks the entry RAM (one write and one read port):
//   a read state and an event test per entry for collision, delete and
//   disable, plus a contact test for tick (read, expiry test, contact
//   test), and one closing state ends the item.
// Stalls: reports pass through a one-deep pending slot and an output
//   register; while out_ch is stalled the walk pauses at the next report.
// Reset: rst_n (synchronous, active low) empties the table, enables the
//   block and loads the register defaults; no clearing pass is needed.
// ---------------------------------------------------------------------------
`include "contact_table_with_aging_macros.svh"

module contact_table_with_aging (
  input  logic                           clk,
  input  logic                           rst_n,
  cta_in_if.sink                         in_ch,
  cta_out_if.source                      out_ch,
  input  logic                           cfg_we,
  input  logic [cta_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cta_pkg::CFG_W-1:0]      cfg_data
);
  import cta_pkg::*;

  // Configuration
  logic [31:0] mask_r;
  logic [15:0] timeout_r;
  logic [15:0] period_r;
  logic [15:0] period_used;

  // Control state
  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              is_on_r, is_on_nxt;
  logic              pend_valid_r, pend_valid_nxt;
  logic              out_valid_r, out_valid_nxt;

  // Item and walk registers
  op_t               op_r, op_nxt;
  logic [31:0]       now_r, now_nxt;
  logic [15:0]       id_r, id_nxt;
  logic [31:0]       type_r, type_nxt;
  logic              en_r, en_nxt;
  logic [31:0]       exp_new_r, exp_new_nxt;
  logic [31:0]       nc_new_r, nc_new_nxt;
  logic [IDX_W-1:0]  rp_r, rp_nxt;
  logic [IDX_W-1:0]  wp_r, wp_nxt;
  logic              found_r, found_nxt;
  kind_t             pend_kind_r, pend_kind_nxt;
  logic [15:0]       pend_who_r, pend_who_nxt;
  kind_t             out_kind_r, out_kind_nxt;
  logic [15:0]       out_who_r, out_who_nxt;
  logic              out_last_r, out_last_nxt;

  // Table RAM and time unit
  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  entry_t            wr_data;
  logic              rd_en;
  logic [IDX_W-1:0]  rd_addr;
  entry_t            rd_data;
  tu_req_t           tu_req;
  tu_rsp_t           tu_rsp;

  // Report production
  logic              prod_req;
  kind_t             prod_kind;
  logic [15:0]       prod_who;
  logic              emit_ok;
  logic              stall;
  logic              out_load;
  logic              in_acc;
  logic              last_row;
  logic              id_hit;
  logic              room;

  cta_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (CAPACITY)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  cta_time_unit u_time (
    .req (tu_req),
    .rsp (tu_rsp)
  );

  // Handshake and walk status
  assign in_ch.ready  = (state_r == ST_IDLE);
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign emit_ok      = !out_valid_r || out_ch.ready;
  assign stall        = prod_req && pend_valid_r && !emit_ok;
  assign last_row     = ((CNT_W'(rp_r) + CNT_W'(1)) == count_r);
  assign id_hit       = (rd_data.id == id_r);
  assign room         = (count_r < CNT_W'(CAPACITY));
  assign period_used  = (period_r < MIN_PERIOD_MS) ? MIN_PERIOD_MS : period_r;

  assign out_ch.valid = out_valid_r;
  assign out_ch.kind  = out_kind_r;
  assign out_ch.who   = out_who_r;
  assign out_ch.last  = out_last_r;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = ST_SUM_T;
        end
      end
      ST_SUM_T: begin
        state_nxt = ST_SUM_P;
      end
      ST_SUM_P: begin
        case (op_r)
          OP_COLLIDE: begin
            if ((type_r & mask_r) == 32'd0) begin
              state_nxt = ST_FIN;
            end else if (count_r == '0) begin
              state_nxt = ST_ADD;
            end else begin
              state_nxt = ST_RD;
            end
          end
          OP_TICK, OP_DELETE: begin
            state_nxt = (count_r == '0) ? ST_FIN : ST_RD;
          end
          OP_ENABLE: begin
            if (is_on_r == en_r) begin
              state_nxt = ST_FIN;
            end else if (en_r || (count_r == '0)) begin
              state_nxt = ST_MARK;
            end else begin
              state_nxt = ST_RD;
            end
          end
          default: state_nxt = ST_FIN;
        endcase
      end
      ST_RD: begin
        state_nxt = ST_EV;
      end
      ST_EV: begin
        if (!stall) begin
          case (op_r)
            OP_COLLIDE: begin
              if (id_hit) begin
                state_nxt = ST_FIN;
              end else begin
                state_nxt = last_row ? ST_ADD : ST_RD;
              end
            end
            OP_TICK: begin
              if (tu_rsp.reached) begin
                state_nxt = last_row ? ST_FIN : ST_RD;
              end else begin
                state_nxt = ST_CON;
              end
            end
            OP_DELETE: begin
              state_nxt = last_row ? ST_FIN : ST_RD;
            end
            OP_ENABLE: begin
              state_nxt = (rp_r == '0) ? ST_MARK : ST_RD;
            end
            default: state_nxt = ST_FIN;
          endcase
        end
      end
      ST_CON: begin
        if (!stall) begin
          state_nxt = last_row ? ST_FIN : ST_RD;
        end
      end
      ST_ADD, ST_MARK: begin
        if (!stall) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (emit_ok) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs per state: time unit, RAM access, report requests
  always_comb begin
    tu_req    = '{op: TU_ADD, a: now_r, b: 32'd0};
    rd_en     = 1'b0;
    rd_addr   = rp_r;
    wr_en     = 1'b0;
    wr_addr   = wp_r;
    wr_data   = rd_data;
    prod_req  = 1'b0;
    prod_kind = KIND_NONE;
    prod_who  = 16'd0;
    case (state_r)
      ST_SUM_T: begin
        tu_req = '{op: TU_ADD, a: now_r, b: {16'd0, timeout_r}};
      end
      ST_SUM_P: begin
        tu_req = '{op: TU_ADD, a: now_r, b: {16'd0, period_used}};
      end
      ST_RD: begin
        rd_en = 1'b1;
      end
      ST_EV: begin
        tu_req = '{op: TU_SUB, a: now_r, b: rd_data.expiry};
        case (op_r)
          OP_COLLIDE: begin
            // Refresh a known entry in place
            if (id_hit) begin
              wr_en   = 1'b1;
              wr_addr = rp_r;
              wr_data = '{id: rd_data.id, expiry: exp_new_r,
                          next_contact: rd_data.next_contact};
            end
          end
          OP_TICK: begin
            if (tu_rsp.reached) begin
              prod_req  = 1'b1;
              prod_kind = KIND_LEAVE;
              prod_who  = rd_data.id;
            end
          end
          OP_DELETE: begin
            // Compact: keep every row but the first match
            wr_en = !(id_hit && !found_r);
          end
          OP_ENABLE: begin
            prod_req  = 1'b1;
            prod_kind = KIND_LEAVE;
            prod_who  = rd_data.id;
          end
          default: ;
        endcase
      end
      ST_CON: begin
        tu_req = '{op: TU_SUB, a: now_r, b: rd_data.next_contact};
        wr_en  = !stall;
        if (tu_rsp.reached) begin
          prod_req  = 1'b1;
          prod_kind = KIND_CONTACT;
          prod_who  = rd_data.id;
          wr_data   = '{id: rd_data.id, expiry: rd_data.expiry,
                        next_contact: nc_new_r};
        end
      end
      ST_ADD: begin
        prod_req = 1'b1;
        prod_who = id_r;
        if (room) begin
          prod_kind = KIND_ENTER;
          wr_en     = !stall;
          wr_addr   = count_r[IDX_W-1:0];
          wr_data   = '{id: id_r, expiry: exp_new_r, next_contact: nc_new_r};
        end else begin
          prod_kind = KIND_REJECTED;
        end
      end
      ST_MARK: begin
        prod_req  = 1'b1;
        prod_kind = is_on_r ? KIND_ENABLED : KIND_DISABLED;
      end
      default: ;
    endcase
  end

  // Datapath next values
  always_comb begin
    count_nxt      = count_r;
    is_on_nxt      = is_on_r;
    op_nxt         = op_r;
    now_nxt        = now_r;
    id_nxt         = id_r;
    type_nxt       = type_r;
    en_nxt         = en_r;
    exp_new_nxt    = exp_new_r;
    nc_new_nxt     = nc_new_r;
    rp_nxt         = rp_r;
    wp_nxt         = wp_r;
    found_nxt      = found_r;
    pend_valid_nxt = pend_valid_r;
    pend_kind_nxt  = pend_kind_r;
    pend_who_nxt   = pend_who_r;
    out_load       = 1'b0;
    out_kind_nxt   = out_kind_r;
    out_who_nxt    = out_who_r;
    out_last_nxt   = out_last_r;

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          op_nxt   = op_t'(in_ch.op);
          now_nxt  = in_ch.now_ms;
          id_nxt   = in_ch.object_id;
          type_nxt = in_ch.object_type;
          en_nxt   = in_ch.enable_value;
        end
      end
      ST_SUM_T: begin
        exp_new_nxt = tu_rsp.sum;
      end
      ST_SUM_P: begin
        nc_new_nxt = tu_rsp.sum;
        rp_nxt     = '0;
        wp_nxt     = '0;
        found_nxt  = 1'b0;
        if ((op_r == OP_ENABLE) && (is_on_r != en_r)) begin
          is_on_nxt = en_r;
          // Flush walks from the last entry down
          rp_nxt    = IDX_W'(count_r - CNT_W'(1));
        end
      end
      ST_EV: begin
        if (!stall) begin
          case (op_r)
            OP_COLLIDE: begin
              rp_nxt = rp_r + IDX_W'(1);
            end
            OP_TICK: begin
              if (tu_rsp.reached) begin
                rp_nxt = rp_r + IDX_W'(1);
                if (last_row) begin
                  count_nxt = CNT_W'(wp_r);
                end
              end
            end
            OP_DELETE: begin
              rp_nxt = rp_r + IDX_W'(1);
              if (id_hit && !found_r) begin
                found_nxt = 1'b1;
                if (last_row) begin
                  count_nxt = CNT_W'(wp_r);
                end
              end else begin
                wp_nxt = wp_r + IDX_W'(1);
                if (last_row) begin
                  count_nxt = CNT_W'(wp_r) + CNT_W'(1);
                end
              end
            end
            OP_ENABLE: begin
              rp_nxt    = rp_r - IDX_W'(1);
              count_nxt = count_r - CNT_W'(1);
            end
            default: ;
          endcase
        end
      end
      ST_CON: begin
        if (!stall) begin
          rp_nxt = rp_r + IDX_W'(1);
          wp_nxt = wp_r + IDX_W'(1);
          if (last_row) begin
            count_nxt = CNT_W'(wp_r) + CNT_W'(1);
          end
        end
      end
      ST_ADD: begin
        if (!stall && room) begin
          count_nxt = count_r + CNT_W'(1);
        end
      end
      ST_FIN: begin
        // Close the item: the pending report, or a none report, goes out last
        if (emit_ok) begin
          out_load       = 1'b1;
          out_kind_nxt   = pend_valid_r ? pend_kind_r : KIND_NONE;
          out_who_nxt    = pend_valid_r ? pend_who_r : 16'd0;
          out_last_nxt   = 1'b1;
          pend_valid_nxt = 1'b0;
        end
      end
      default: ;
    endcase

    // Push a new report into the pending slot, moving the older one out
    if (prod_req && !stall) begin
      if (pend_valid_r) begin
        out_load     = 1'b1;
        out_kind_nxt = pend_kind_r;
        out_who_nxt  = pend_who_r;
        out_last_nxt = 1'b0;
      end
      pend_valid_nxt = 1'b1;
      pend_kind_nxt  = prod_kind;
      pend_who_nxt   = prod_who;
    end
  end

  assign out_valid_nxt = out_load || (out_valid_r && !out_ch.ready);

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      count_r      <= '0;
      is_on_r      <= 1'b1;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
      mask_r       <= RST_TYPE_MASK;
      timeout_r    <= RST_TIMEOUT_MS;
      period_r     <= RST_PERIOD_MS;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      is_on_r      <= is_on_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_TYPE_MASK: mask_r    <= cfg_data[31:0];
          CFG_TIMEOUT:   timeout_r <= cfg_data[15:0];
          CFG_PERIOD:    period_r  <= cfg_data[15:0];
          default: ;
        endcase
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    now_r       <= now_nxt;
    id_r        <= id_nxt;
    type_r      <= type_nxt;
    en_r        <= en_nxt;
    exp_new_r   <= exp_new_nxt;
    nc_new_r    <= nc_new_nxt;
    rp_r        <= rp_nxt;
    wp_r        <= wp_nxt;
    found_r     <= found_nxt;
    pend_kind_r <= pend_kind_nxt;
    pend_who_r  <= pend_who_nxt;
    out_kind_r  <= out_kind_nxt;
    out_who_r   <= out_who_nxt;
    out_last_r  <= out_last_nxt;
  end

  // Checks
  `CTA_ASSERT_IMPLY(a_idle_no_pending, in_ch.ready, !pend_valid_r)
  `CTA_ASSERT_IMPLY(a_load_when_free, out_load, emit_ok)
  `CTA_ASSERT_NEXT(a_fin_closes, (state_r == ST_FIN) && emit_ok, out_valid_r && out_last_r)
  `CTA_ASSERT_IMPLY(a_count_bound, 1'b1, count_r <= CNT_W'(CAPACITY))

endmodule

// ===== tb/contact_table_with_aging_tb.sv =====
// ---------------------------------------------------------------------------
// Contact table with aging testbench
// Drives collision, tick, delete and enable events through the valid/ready
// input channel and checks every report against an in-bench table model.
// It runs a short directed sequence, then random phases, each with its own
// register setting and an idle/stall pattern.
// ---------------------------------------------------------------------------
module contact_table_with_aging_tb;
  import cta_pkg::*;

  localparam int POOL_SIZE    = 20;
  localparam int DRAIN_CYCLES = 60;

  typedef struct {
    op_t         op;
    logic [31:0] now_ms;
    logic [15:0] object_id;
    logic [31:0] object_type;
    logic        enable_value;
  } event_t;

  typedef struct {
    kind_t       kind;
    logic [15:0] who;
    logic        last;
  } report_t;

  logic clk;
  logic rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  cta_in_if  in_bus();
  cta_out_if out_bus();

  contact_table_with_aging u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_bus),
    .out_ch    (out_bus),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Stimulus and scoreboard storage
  event_t  event_q[$];
  report_t report_q[$];
  event_t  next_ev;
  event_t  seen_ev;
  report_t want;
  int      events_sent;
  int      events_taken;
  int      reports_checked;
  int      fail_count;
  int      kind_seen[8];
  int      src_idle_pct;
  int      snk_stall_pct;
  logic    in_taken;

  // Shadow registers and contact table
  logic [31:0] mask_q;
  logic [15:0] timeout_q;
  logic [15:0] period_q;
  logic [15:0] tab_id      [CAPACITY];
  logic [31:0] tab_expiry  [CAPACITY];
  logic [31:0] tab_contact [CAPACITY];
  int          tab_count;
  bit          region_on;

  // Random sequence state
  logic [31:0] sim_ms;
  logic [15:0] id_pool [POOL_SIZE];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("[contact_table_with_aging] ERROR");
    $finish;
  end

  // A deadline has come when now - when, taken as signed, is not negative
  function automatic bit has_come(logic [31:0] when, logic [31:0] now);
    logic [31:0] diff;
    diff = now - when;
    return !diff[31];
  endfunction

  function automatic report_t make_report(kind_t k, logic [15:0] w);
    report_t r;
    r.kind = k;
    r.who  = w;
    r.last = 1'b0;
    return r;
  endfunction

  // Close the gap left by entry pos
  task automatic remove_entry(input int pos);
    int j;
    for (j = pos; j + 1 < tab_count; j++) begin
      tab_id[j]      = tab_id[j + 1];
      tab_expiry[j]  = tab_expiry[j + 1];
      tab_contact[j] = tab_contact[j + 1];
    end
    if (tab_count > 0) tab_count--;
  endtask

  // Update the table for one event and queue the reports it must produce
  task automatic predict_reports(input event_t ev);
    report_t     pend[$];
    logic [31:0] period;
    logic [31:0] expiry;
    int          i;
    bit          found;
    period = (period_q < MIN_PERIOD_MS) ? {16'd0, MIN_PERIOD_MS} : {16'd0, period_q};
    expiry = ev.now_ms + {16'd0, timeout_q};
    case (ev.op)
      OP_COLLIDE: begin
        if ((ev.object_type & mask_q) != 32'd0) begin
          found = 1'b0;
          for (i = 0; i < tab_count; i++) begin
            if (tab_id[i] == ev.object_id) begin
              tab_expiry[i] = expiry;
              found = 1'b1;
              break;
            end
          end
          if (!found && tab_count < CAPACITY) begin
            tab_id[tab_count]      = ev.object_id;
            tab_expiry[tab_count]  = expiry;
            tab_contact[tab_count] = ev.now_ms + period;
            tab_count++;
            pend.push_back(make_report(KIND_ENTER, ev.object_id));
          end else if (!found) begin
            pend.push_back(make_report(KIND_REJECTED, ev.object_id));
          end
        end
      end
      OP_TICK: begin
        i = 0;
        while (i < tab_count) begin
          if (has_come(tab_expiry[i], ev.now_ms)) begin
            pend.push_back(make_report(KIND_LEAVE, tab_id[i]));
            remove_entry(i);
          end else begin
            if (has_come(tab_contact[i], ev.now_ms)) begin
              pend.push_back(make_report(KIND_CONTACT, tab_id[i]));
              tab_contact[i] = ev.now_ms + period;
            end
            i++;
          end
        end
      end
      OP_DELETE: begin
        for (i = 0; i < tab_count; i++) begin
          if (tab_id[i] == ev.object_id) begin
            remove_entry(i);
            break;
          end
        end
      end
      default: begin
        if (region_on != ev.enable_value) begin
          region_on = ev.enable_value;
          if (!ev.enable_value) begin
            // Flush last to first
            while (tab_count > 0) begin
              pend.push_back(make_report(KIND_LEAVE, tab_id[tab_count - 1]));
              tab_count--;
            end
            pend.push_back(make_report(KIND_DISABLED, 16'd0));
          end else begin
            pend.push_back(make_report(KIND_ENABLED, 16'd0));
          end
        end
      end
    endcase
    if (pend.size() == 0) pend.push_back(make_report(KIND_NONE, 16'd0));
    pend[pend.size() - 1].last = 1'b1;
    foreach (pend[k]) report_q.push_back(pend[k]);
  endtask

  // Sample input transfers and check output transfers
  always @(posedge clk) begin
    if (!rst_n) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_bus.valid && in_bus.ready;
      if (in_bus.valid && in_bus.ready) begin
        seen_ev.op           = op_t'(in_bus.op);
        seen_ev.now_ms       = in_bus.now_ms;
        seen_ev.object_id    = in_bus.object_id;
        seen_ev.object_type  = in_bus.object_type;
        seen_ev.enable_value = in_bus.enable_value;
        predict_reports(seen_ev);
        events_taken++;
      end
      if (out_bus.valid && out_bus.ready) begin
        if (report_q.size() == 0) begin
          $error("unexpected report: kind %0d who %h last %b",
                 out_bus.kind, out_bus.who, out_bus.last);
          fail_count++;
        end else begin
          want = report_q.pop_front();
          if (out_bus.kind !== want.kind) begin
            $error("kind: expected %0d, got %0d", want.kind, out_bus.kind);
            fail_count++;
          end
          if (out_bus.who !== want.who) begin
            $error("who: expected %h, got %h", want.who, out_bus.who);
            fail_count++;
          end
          if (out_bus.last !== want.last) begin
            $error("last: expected %b, got %b", want.last, out_bus.last);
            fail_count++;
          end
          kind_seen[want.kind]++;
          reports_checked++;
        end
      end
    end
  end

  // Present events and stall the result channel
  always @(negedge clk) begin
    if (!rst_n) begin
      in_bus.valid  <= 1'b0;
      out_bus.ready <= 1'b0;
    end else begin
      if (in_bus.valid && !in_taken) begin
        // hold the current event until it transfers
      end else if (event_q.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
        next_ev = event_q.pop_front();
        in_bus.op           <= next_ev.op;
        in_bus.now_ms       <= next_ev.now_ms;
        in_bus.object_id    <= next_ev.object_id;
        in_bus.object_type  <= next_ev.object_type;
        in_bus.enable_value <= next_ev.enable_value;
        in_bus.valid        <= 1'b1;
      end else begin
        in_bus.valid <= 1'b0;
      end
      out_bus.ready <= ($urandom_range(0, 99) >= snk_stall_pct);
    end
  end

  task automatic queue_event(input op_t op, input logic [31:0] now, input logic [15:0] id,
                             input logic [31:0] otype, input logic en);
    event_t ev;
    ev.op           = op;
    ev.now_ms       = now;
    ev.object_id    = id;
    ev.object_type  = otype;
    ev.enable_value = en;
    event_q.push_back(ev);
    events_sent++;
  endtask

  // Write one register while the block is idle
  task automatic set_reg(input cfg_idx_t idx, input logic [31:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_TYPE_MASK: mask_q    = data;
      CFG_TIMEOUT:   timeout_q = data[15:0];
      default:       period_q  = data[15:0];
    endcase
  endtask

  // Hold off until every event has transferred and every report has come
  task automatic wait_for_reports();
    while (events_taken != events_sent || report_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Offer one more collision than the table holds, flush it with a disable, then enable again
  task automatic queue_fill_and_flush();
    int k;
    queue_event(OP_ENABLE, sim_ms, 16'd0, 32'd0, 1'b1);
    for (k = 0; k <= CAPACITY; k++) begin
      sim_ms = sim_ms + 1;
      queue_event(OP_COLLIDE, sim_ms, id_pool[k], mask_q, 1'b0);
    end
    queue_event(OP_ENABLE, sim_ms, 16'd0, 32'd0, 1'b0);
    queue_event(OP_ENABLE, sim_ms, 16'd0, 32'd0, 1'b1);
  endtask

  task automatic queue_random_event();
    int          roll;
    logic [31:0] otype;
    logic [15:0] id;
    roll = $urandom_range(0, 99);
    id   = ($urandom_range(0, 9) == 0) ? 16'($urandom)
                                       : id_pool[$urandom_range(0, POOL_SIZE - 1)];
    if (roll < 52) begin
      sim_ms = sim_ms + $urandom_range(0, 5);
      otype  = ($urandom_range(0, 9) < 7) ? $urandom : (32'd1 << $urandom_range(0, 31));
      queue_event(OP_COLLIDE, sim_ms, id, otype, 1'($urandom));
    end else if (roll < 78) begin
      roll = $urandom_range(0, 99);
      if (roll < 80)      sim_ms = sim_ms + $urandom_range(0, 100);
      else if (roll < 95) sim_ms = sim_ms + $urandom_range(0, 1000);
      else                sim_ms = sim_ms + $urandom;
      queue_event(OP_TICK, sim_ms, 16'($urandom), $urandom, 1'($urandom));
    end else if (roll < 89) begin
      queue_event(OP_DELETE, sim_ms, id, $urandom, 1'($urandom));
    end else if (roll < 96) begin
      queue_event(OP_ENABLE, sim_ms, 16'($urandom), $urandom, ($urandom_range(0, 3) != 0));
    end else begin
      // noise: any op with fully random fields
      queue_event(op_t'($urandom_range(0, 3)), $urandom, 16'($urandom), $urandom,
                  1'($urandom));
    end
  endtask

  task automatic run_phase(input int src_pct, input int snk_pct, input logic [31:0] mask,
                           input logic [31:0] timeout, input logic [31:0] period,
                           input logic [31:0] start_ms, input int n_events);
    int k;
    set_reg(CFG_TYPE_MASK, mask);
    set_reg(CFG_TIMEOUT, timeout);
    set_reg(CFG_PERIOD, period);
    for (k = 0; k < POOL_SIZE; k++) id_pool[k] = 16'(($urandom & 32'h07FF) | (k << 11));
    sim_ms = start_ms;
    @(posedge clk);
    src_idle_pct  = src_pct;
    snk_stall_pct = snk_pct;
    for (k = 0; k < n_events; k++) begin
      if (k == n_events / 2) queue_fill_and_flush();
      queue_random_event();
    end
    wait_for_reports();
  endtask

  initial begin
    in_bus.valid        = 1'b0;
    in_bus.op           = OP_COLLIDE;
    in_bus.now_ms       = 32'd0;
    in_bus.object_id    = 16'd0;
    in_bus.object_type  = 32'd0;
    in_bus.enable_value = 1'b0;
    out_bus.ready       = 1'b0;
    cfg_we              = 1'b0;
    cfg_index           = CFG_TYPE_MASK;
    cfg_data            = 32'd0;
    rst_n               = 1'b0;
    mask_q              = RST_TYPE_MASK;
    timeout_q           = RST_TIMEOUT_MS;
    period_q            = RST_PERIOD_MS;
    tab_count           = 0;
    region_on           = 1'b1;
    events_sent         = 0;
    events_taken        = 0;
    reports_checked     = 0;
    fail_count          = 0;
    src_idle_pct        = 0;
    snk_stall_pct       = 0;
    foreach (kind_seen[k]) kind_seen[k] = 0;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset register values, field extremes, every op and case
    queue_event(OP_COLLIDE, 32'd0,   16'h0000, 32'h0000_0001, 1'b0);
    queue_event(OP_COLLIDE, 32'd10,  16'hFFFF, 32'h8000_0000, 1'b1);
    queue_event(OP_COLLIDE, 32'd20,  16'h0000, 32'hFFFF_FFFF, 1'b0);
    queue_event(OP_COLLIDE, 32'd25,  16'h0005, 32'h0000_0000, 1'b0);
    queue_event(OP_TICK,    32'd100, 16'h0000, 32'h0000_0000, 1'b0);
    queue_event(OP_TICK,    32'd250, 16'h0000, 32'h0000_0000, 1'b0);
    queue_event(OP_TICK,    32'd260, 16'h0000, 32'h0000_0000, 1'b0);
    queue_event(OP_DELETE,  32'd261, 16'h1234, 32'h0000_0000, 1'b0);
    queue_event(OP_COLLIDE, 32'd262, 16'h00A5, 32'h0000_0010, 1'b0);
    queue_event(OP_DELETE,  32'd263, 16'h00A5, 32'h0000_0000, 1'b0);
    queue_event(OP_ENABLE,  32'd264, 16'h0000, 32'h0000_0000, 1'b1);
    queue_event(OP_ENABLE,  32'd265, 16'h0000, 32'h0000_0000, 1'b0);
    queue_event(OP_COLLIDE, 32'd266, 16'h0007, 32'h0000_0004, 1'b0);
    queue_event(OP_ENABLE,  32'd267, 16'h0000, 32'h0000_0000, 1'b0);
    queue_event(OP_ENABLE,  32'd268, 16'h0000, 32'h0000_0000, 1'b1);
    queue_event(OP_TICK,    32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 1'b1);
    queue_event(OP_TICK,    32'h7FFF_FFFF, 16'h0000, 32'h0000_0000, 1'b0);
    wait_for_reports();

    // Random phases: register extremes, wrap of time, idle and stall patterns
    run_phase(0,  0,  32'hFFFF_FFFF, 32'd65535,       32'd33,    32'd1000,      20);
    run_phase(81, 0,  32'h0000_00F0, 32'd0,           32'd0,     32'h0001_0000, 20);
    run_phase(0,  81, 32'h8000_0001, 32'd300,         32'd65535, 32'hFFFF_FF00, 20);
    run_phase(30, 30, 32'h0000_0000, 32'd1,           32'd32,    32'h4000_0000, 15);
    run_phase(30, 30, $urandom | 32'h1, 32'hABCD_00FA, 32'd100,  $urandom,      20);
    run_phase(0,  0,  32'hFFFF_FFFF, 32'd1000,        32'd500,   32'h7FFF_FF00, 20);

    $display("covered %0d events and %0d reports: enter %0d, contact %0d, leave %0d,",
             events_taken, reports_checked, kind_seen[KIND_ENTER], kind_seen[KIND_CONTACT],
             kind_seen[KIND_LEAVE]);
    $display("  rejected %0d, enabled %0d, disabled %0d, none %0d; %0d mismatches",
             kind_seen[KIND_REJECTED], kind_seen[KIND_ENABLED], kind_seen[KIND_DISABLED],
             kind_seen[KIND_NONE], fail_count);
    if (fail_count == 0) begin
      $display("[contact_table_with_aging] OK");
    end else begin
      $display("[contact_table_with_aging] ERROR");
    end
    $finish;
  end

endmodule
